@@ design/rhcv_pkg.sv @@
// ----------------------------------------------------------------------------
// rhcv_pkg
// Shared types, codes and helpers for the region HSV color vote block.
// ----------------------------------------------------------------------------
`default_nettype none

package rhcv_pkg;

    localparam int MAX_IMAGE_DIM = 2048;
    localparam int DIM_W         = 12;
    localparam int BOX_W         = 13;
    localparam int POS_W         = 14;
    localparam int COORD_W       = 11;
    localparam int CNT_W         = 23;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;

    typedef logic [2:0]           t_color;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic signed [POS_W-1:0] t_pos;

    localparam t_color COLOR_NONE   = 3'd0;
    localparam t_color COLOR_BLUE   = 3'd1;
    localparam t_color COLOR_GREEN  = 3'd2;
    localparam t_color COLOR_YELLOW = 3'd3;
    localparam t_color COLOR_WHITE  = 3'd4;
    localparam t_color COLOR_BLACK  = 3'd5;

    localparam t_cfg_idx REG_IMAGE_WIDTH  = 3'd0;
    localparam t_cfg_idx REG_IMAGE_HEIGHT = 3'd1;
    localparam t_cfg_idx REG_BOX_LEFT     = 3'd2;
    localparam t_cfg_idx REG_BOX_RIGHT    = 3'd3;
    localparam t_cfg_idx REG_BOX_TOP      = 3'd4;
    localparam t_cfg_idx REG_BOX_BOTTOM   = 3'd5;

    // span / 6, truncated toward zero, for |span| < 2^13; reciprocal 10923 / 2^16 is exact there
    function automatic t_pos div6(input t_pos span);
        logic [POS_W-1:0] mag;
        logic [26:0]      prod;
        t_pos             q;
        mag  = span[POS_W-1] ? POS_W'(-span) : POS_W'(span);
        prod = 27'(mag[12:0]) * 27'd10923;
        q    = t_pos'({3'b000, prod[26:16]});
        return span[POS_W-1] ? -q : q;
    endfunction

    function automatic t_pos region_lo(input logic signed [BOX_W-1:0] lo,
                                       input logic signed [BOX_W-1:0] hi);
        t_pos a;
        a = t_pos'(lo) + div6(t_pos'(hi) - t_pos'(lo));
        return a[POS_W-1] ? t_pos'(0) : a;
    endfunction

    function automatic t_pos region_hi(input logic signed [BOX_W-1:0] lo,
                                       input logic signed [BOX_W-1:0] hi,
                                       input logic [DIM_W-1:0]        dim);
        logic [DIM_W-1:0] dim_sat;
        t_pos             b;
        t_pos             lim;
        dim_sat = (dim > DIM_W'(MAX_IMAGE_DIM)) ? DIM_W'(MAX_IMAGE_DIM) : dim;
        b       = t_pos'(hi) - div6(t_pos'(hi) - t_pos'(lo));
        lim     = t_pos'({2'b00, dim_sat}) - t_pos'(1);
        return (b > lim) ? lim : b;
    endfunction

endpackage

`default_nettype wire

@@ design/rhcv_classify.sv @@
// ----------------------------------------------------------------------------
// rhcv_classify
// HSV class of one RGB pixel by exact integer cross-multiplied compares.
// ----------------------------------------------------------------------------
`default_nettype none

module rhcv_classify
    import rhcv_pkg::*;
(
    input  wire logic [7:0] i_red,
    input  wire logic [7:0] i_green,
    input  wire logic [7:0] i_blue,
    output t_color          o_color
);

    logic [7:0]         mx;
    logic [7:0]         mn;
    logic signed [19:0] s_r, s_g, s_b, s_mx, s_d, h;
    logic               bright;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue  > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue  < mn) mn = i_blue;
        s_r  = {12'd0, i_red};
        s_g  = {12'd0, i_green};
        s_b  = {12'd0, i_blue};
        s_mx = {12'd0, mx};
        s_d  = {12'd0, mx - mn};

        // hue scaled by d; ties pick red, then green
        if (mx == i_red) begin
            h = 20'sd60 * (s_g - s_b);
        end else if (mx == i_green) begin
            h = 20'sd60 * (s_b - s_r) + 20'sd120 * s_d;
        end else begin
            h = 20'sd60 * (s_r - s_g) + 20'sd240 * s_d;
        end
        if (h < 20'sd0) h = h + 20'sd360 * s_d;

        bright = (20'sd100 * s_mx) > 20'sd4080;

        if ((20'sd20 * s_mx) < 20'sd765) begin
            o_color = COLOR_BLACK;
        end else if (s_d > 20'sd0 && bright && h >= 20'sd190 * s_d &&
                     h <= 20'sd260 * s_d && (20'sd100 * s_d) > (20'sd23 * s_mx)) begin
            o_color = COLOR_BLUE;
        end else if (s_d > 20'sd0 && bright && h >= 20'sd75 * s_d &&
                     h <= 20'sd155 * s_d && (20'sd5 * s_d) > s_mx) begin
            o_color = COLOR_GREEN;
        end else if (s_d > 20'sd0 && bright && h >= 20'sd15 * s_d &&
                     h <= 20'sd55 * s_d && (20'sd20 * s_d) > (20'sd3 * s_mx)) begin
            o_color = COLOR_YELLOW;
        end else if ((20'sd20 * s_d) < (20'sd3 * s_mx) &&
                     (20'sd100 * s_mx) > 20'sd14025) begin
            o_color = COLOR_WHITE;
        end else begin
            o_color = COLOR_NONE;
        end
    end

endmodule

`default_nettype wire

@@ design/region_hsv_color_vote.sv @@
// ----------------------------------------------------------------------------
// region_hsv_color_vote
// Counts HSV color classes of pixels in the inner box region and votes a
// plate color at the end of each frame.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock with no gaps needed. A pixel passes an input
// register, a classify register and the counter stage; the word carrying
// frame_end copies the final counts to a snapshot, from which the vote is
// registered into the output word. Pixel flow stalls only when a frame_end
// word meets a full snapshot and a stalled output. Region bounds are registered
// from the configuration registers.
`default_nettype none

module region_hsv_color_vote
    import rhcv_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [7:0]             i_red,
    input  wire logic [7:0]             i_green,
    input  wire logic [7:0]             i_blue,
    input  wire logic [COORD_W-1:0]     i_column,
    input  wire logic [COORD_W-1:0]     i_row,
    input  wire logic                   i_frame_end,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [2:0]                  o_vote_color,
    output logic [CNT_W-1:0]            o_sampled_pixels
);

    // configuration
    logic [DIM_W-1:0]        r_image_width, r_image_height;
    logic signed [BOX_W-1:0] r_box_left, r_box_right, r_box_top, r_box_bottom;
    t_pos                    r_col_lo, r_col_hi, r_row_lo, r_row_hi;

    // stage 1
    logic               r_s1_valid;
    logic [7:0]         r_s1_red, r_s1_green, r_s1_blue;
    logic [COORD_W-1:0] r_s1_column, r_s1_row;
    logic               r_s1_last;

    // stage 2
    logic   r_s2_valid;
    logic   r_s2_in;
    t_color r_s2_cls;
    logic   r_s2_last;
    t_color cls;
    logic   in_region;

    // counters, snapshot, output
    t_cnt   r_total;
    t_cnt   r_cnt [1:5];
    t_cnt   n_total;
    t_cnt   n_cnt [1:5];
    logic   r_snap_valid;
    t_cnt   r_snap_total;
    t_cnt   r_snap_cnt [1:5];
    logic   r_out_valid;
    t_color r_out_color;
    t_cnt   r_out_total;
    t_color vote;

    logic out_free, snap_ready, cnt_go, s2_ready, s1_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_W'(MAX_IMAGE_DIM);
            r_image_height <= DIM_W'(MAX_IMAGE_DIM);
            r_box_left     <= '0;
            r_box_right    <= '0;
            r_box_top      <= '0;
            r_box_bottom   <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[DIM_W-1:0];
                REG_BOX_LEFT:     r_box_left     <= i_cfg_data;
                REG_BOX_RIGHT:    r_box_right    <= i_cfg_data;
                REG_BOX_TOP:      r_box_top      <= i_cfg_data;
                REG_BOX_BOTTOM:   r_box_bottom   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_col_lo <= region_lo(r_box_left, r_box_right);
        r_col_hi <= region_hi(r_box_left, r_box_right, r_image_width);
        r_row_lo <= region_lo(r_box_top, r_box_bottom);
        r_row_hi <= region_hi(r_box_top, r_box_bottom, r_image_height);
    end

    // handshake chain
    assign out_free   = !r_out_valid || i_ready;
    assign snap_ready = !r_snap_valid || out_free;
    assign cnt_go     = r_s2_valid && (!r_s2_last || snap_ready);
    assign s2_ready   = !r_s2_valid || cnt_go;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_ready    = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready) begin
            r_s1_red    <= i_red;
            r_s1_green  <= i_green;
            r_s1_blue   <= i_blue;
            r_s1_column <= i_column;
            r_s1_row    <= i_row;
            r_s1_last   <= i_frame_end;
        end
    end

    rhcv_classify u_classify (
        .i_red   (r_s1_red),
        .i_green (r_s1_green),
        .i_blue  (r_s1_blue),
        .o_color (cls)
    );

    assign in_region = (t_pos'({3'b000, r_s1_column}) >= r_col_lo) &&
                       (t_pos'({3'b000, r_s1_column}) <= r_col_hi) &&
                       (t_pos'({3'b000, r_s1_row}) >= r_row_lo) &&
                       (t_pos'({3'b000, r_s1_row}) <= r_row_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready) begin
            r_s2_in   <= in_region;
            r_s2_cls  <= cls;
            r_s2_last <= r_s1_last;
        end
    end

    // saturating counts
    always_comb begin
        n_total = r_total;
        if (r_s2_in && r_total != '1) n_total = r_total + t_cnt'(1);
        for (int k = 1; k <= 5; k++) begin
            n_cnt[k] = r_cnt[k];
            if (r_s2_in && r_s2_cls == t_color'(k) && r_cnt[k] != '1) begin
                n_cnt[k] = r_cnt[k] + t_cnt'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            for (int k = 1; k <= 5; k++) r_cnt[k] <= '0;
        end else if (cnt_go) begin
            r_total <= r_s2_last ? t_cnt'(0) : n_total;
            for (int k = 1; k <= 5; k++) r_cnt[k] <= r_s2_last ? t_cnt'(0) : n_cnt[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (cnt_go && r_s2_last) begin
            r_snap_valid <= 1'b1;
        end else if (out_free) begin
            r_snap_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_go && r_s2_last) begin
            r_snap_total <= n_total;
            for (int k = 1; k <= 5; k++) r_snap_cnt[k] <= n_cnt[k];
        end
    end

    // vote; blue > green + floor(T/20) is 20 * (blue - green) > T
    always_comb begin
        logic [28:0] t;
        logic [28:0] bk, bl, gr, ye, wh;
        logic [28:0] d_bg, d_gb;
        t    = 29'(r_snap_total);
        bk   = 29'(r_snap_cnt[COLOR_BLACK]);
        bl   = 29'(r_snap_cnt[COLOR_BLUE]);
        gr   = 29'(r_snap_cnt[COLOR_GREEN]);
        ye   = 29'(r_snap_cnt[COLOR_YELLOW]);
        wh   = 29'(r_snap_cnt[COLOR_WHITE]);
        d_bg = bl - gr;
        d_gb = gr - bl;
        if (t == 29'd0) begin
            vote = COLOR_NONE;
        end else if (29'd20 * bk >= 29'd9 * t) begin
            vote = COLOR_BLACK;
        end else if (29'd5 * bl >= t && bl > gr && 29'd20 * d_bg > t) begin
            vote = COLOR_BLUE;
        end else if (29'd5 * gr >= t && gr > bl && 29'd20 * d_gb > t) begin
            vote = COLOR_GREEN;
        end else if (29'd50 * ye >= 29'd9 * t) begin
            vote = COLOR_YELLOW;
        end else if (29'd10 * wh >= 29'd3 * t) begin
            vote = COLOR_WHITE;
        end else begin
            vote = COLOR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_snap_valid && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_snap_valid && out_free) begin
            r_out_color <= vote;
            r_out_total <= r_snap_total;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_vote_color     = r_out_color;
    assign o_sampled_pixels = r_out_total;

endmodule

`default_nettype wire

@@ tb/sv/tb_region_hsv_color_vote.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_region_hsv_color_vote
// Self-checking regression for the region HSV color vote block. A short table
// of mostly one-pixel frames probes each color class, coordinate edges and
// pixels outside the one-pixel reset region. Randomized pixel frames then run
// under a series of box and image settings, checked against an in-bench model
// of the inner-region classifier and the end-of-frame vote. Both handshakes
// are throttled at random, with one long output stall and one drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_region_hsv_color_vote;
    import rhcv_pkg::*;

    localparam int          PIPE_CYCLES = 8;
    localparam int          HOLD_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam longint      CNT_SAT     = 64'h7FFFFF;
    localparam int          N_PROBES    = 20;
    localparam int          N_PHASES    = 11;
    localparam t_cfg_idx    REG_SPARE   = 3'd7;

    localparam t_cfg_idx WRITE_ORDER [7] = '{REG_SPARE, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT,
                                             REG_BOX_LEFT, REG_BOX_RIGHT, REG_BOX_TOP,
                                             REG_BOX_BOTTOM};

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               frame_end;
    } t_pixel;

    typedef struct packed {
        t_color color;
        t_cnt   count;
    } t_vote;

    typedef struct packed {
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               frame_end;
        logic               typed;
        t_color             color;
        t_cnt               count;
    } t_probe;

    // reset box covers pixel (0,0) only
    t_probe probes [N_PROBES] = '{
        '{8'd0,   8'd0,   8'd0,   11'd5,    11'd5,    1'b1, 1'b1, COLOR_NONE,   23'd0},
        '{8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    1'b1, 1'b1, COLOR_BLACK,  23'd1},
        '{8'd255, 8'd255, 8'd255, 11'd0,    11'd0,    1'b1, 1'b1, COLOR_WHITE,  23'd1},
        '{8'd0,   8'd0,   8'd255, 11'd0,    11'd0,    1'b1, 1'b1, COLOR_BLUE,   23'd1},
        '{8'd0,   8'd255, 8'd0,   11'd0,    11'd0,    1'b1, 1'b1, COLOR_GREEN,  23'd1},
        '{8'd255, 8'd170, 8'd0,   11'd0,    11'd0,    1'b1, 1'b1, COLOR_YELLOW, 23'd1},
        '{8'd255, 8'd0,   8'd0,   11'd0,    11'd0,    1'b1, 1'b1, COLOR_NONE,   23'd1},
        '{8'd255, 8'd255, 8'd0,   11'd0,    11'd0,    1'b1, 1'b0, COLOR_NONE,   23'd0},
        '{8'd255, 8'd0,   8'd100, 11'd0,    11'd0,    1'b1, 1'b0, COLOR_NONE,   23'd0},
        '{8'd38,  8'd38,  8'd38,  11'd0,    11'd0,    1'b1, 1'b0, COLOR_NONE,   23'd0},
        '{8'd39,  8'd0,   8'd0,   11'd0,    11'd0,    1'b1, 1'b0, COLOR_NONE,   23'd0},
        '{8'd128, 8'd128, 8'd128, 11'd0,    11'd0,    1'b1, 1'b0, COLOR_NONE,   23'd0},
        '{8'd255, 8'd255, 8'd255, 11'd2047, 11'd2047, 1'b1, 1'b1, COLOR_NONE,   23'd0},
        '{8'd255, 8'd255, 8'd255, 11'd0,    11'd2047, 1'b0, 1'b0, COLOR_NONE,   23'd0},
        '{8'd0,   8'd0,   8'd255, 11'd2047, 11'd0,    1'b0, 1'b0, COLOR_NONE,   23'd0},
        '{8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    1'b0, 1'b0, COLOR_NONE,   23'd0},
        '{8'd0,   8'd0,   8'd0,   11'd0,    11'd0,    1'b0, 1'b0, COLOR_NONE,   23'd0},
        '{8'd0,   8'd0,   8'd255, 11'd0,    11'd0,    1'b1, 1'b0, COLOR_NONE,   23'd0},
        '{8'd0,   8'd85,  8'd255, 11'd0,    11'd0,    1'b1, 1'b0, COLOR_NONE,   23'd0},
        '{8'd200, 8'd200, 8'd230, 11'd0,    11'd0,    1'b1, 1'b0, COLOR_NONE,   23'd0}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_red = '0;
    logic [7:0]            i_green = '0;
    logic [7:0]            i_blue = '0;
    logic [COORD_W-1:0]    i_column = '0;
    logic [COORD_W-1:0]    i_row = '0;
    logic                  i_frame_end = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [2:0]            o_vote_color;
    logic [CNT_W-1:0]      o_sampled_pixels;

    t_vote       expected_votes [$];
    int          fails = 0;
    int unsigned cycle_count = 0;
    bit          steady = 1'b0;
    int          hold_asked = 0;
    int          hold_taken = 0;
    int          hold_left = 0;

    // model state
    int     cfg_width = 2048;
    int     cfg_height = 2048;
    int     cfg_left = 0;
    int     cfg_right = 0;
    int     cfg_top = 0;
    int     cfg_bottom = 0;
    longint cnt_total = 0;
    longint cnt_black = 0;
    longint cnt_blue = 0;
    longint cnt_green = 0;
    longint cnt_yellow = 0;
    longint cnt_white = 0;

    region_hsv_color_vote uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_red            (i_red),
        .i_green          (i_green),
        .i_blue           (i_blue),
        .i_column         (i_column),
        .i_row            (i_row),
        .i_frame_end      (i_frame_end),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_vote_color     (o_vote_color),
        .o_sampled_pixels (o_sampled_pixels)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("region_hsv_color_vote regression: fail");
            $finish;
        end
    end

    // output side throttle, with a long hold on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (hold_asked != hold_taken) begin
            hold_taken <= hold_asked;
            hold_left  <= HOLD_CYCLES;
            i_ready    <= 1'b0;
        end else if (steady) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= 16);
        end
    end

    always @(posedge i_clk) begin
        t_vote want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_votes.size() == 0) begin
                $display("%0t: unexpected word, vote_color %0d sampled_pixels %0d",
                         $time, o_vote_color, o_sampled_pixels);
                fails++;
            end else begin
                want = expected_votes.pop_front();
                if (o_vote_color !== want.color) begin
                    $display("%0t: vote_color expected %0d actual %0d",
                             $time, want.color, o_vote_color);
                    fails++;
                end
                if (o_sampled_pixels !== want.count) begin
                    $display("%0t: sampled_pixels expected %0d actual %0d",
                             $time, want.count, o_sampled_pixels);
                    fails++;
                end
            end
        end
    end

    function automatic longint sat_inc(input longint c);
        return (c < CNT_SAT) ? c + 1 : c;
    endfunction

    function automatic bit span_hit(input int pos, input int lo, input int hi, input int dim);
        int span;
        int a;
        int b;
        int lim;
        span = hi - lo;
        a    = lo + span / 6;
        b    = hi - span / 6;
        lim  = (dim > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : dim;
        if (a < 0) a = 0;
        if (b >= lim) b = lim - 1;
        return (pos >= a) && (pos <= b);
    endfunction

    function automatic t_color pixel_class(input int r, input int g, input int b);
        int mx;
        int mn;
        int d;
        int h;
        mx = r;
        mn = r;
        h  = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        if (20 * mx < 3 * 255) return COLOR_BLACK;
        if (d > 0) begin
            if (mx == r) h = 60 * (g - b);
            else if (mx == g) h = 60 * (b - r) + 120 * d;
            else h = 60 * (r - g) + 240 * d;
            if (h < 0) h += 360 * d;
            if (100 * mx > 16 * 255) begin
                if (h >= 190 * d && h <= 260 * d && 100 * d > 23 * mx) return COLOR_BLUE;
                if (h >= 75 * d && h <= 155 * d && 5 * d > mx) return COLOR_GREEN;
                if (h >= 15 * d && h <= 55 * d && 20 * d > 3 * mx) return COLOR_YELLOW;
            end
        end
        if (20 * d < 3 * mx && 100 * mx > 55 * 255) return COLOR_WHITE;
        return COLOR_NONE;
    endfunction

    function automatic t_color plate_vote();
        longint slack;
        slack = cnt_total / 20;
        if (cnt_total == 0) return COLOR_NONE;
        if (20 * cnt_black >= 9 * cnt_total) return COLOR_BLACK;
        if (5 * cnt_blue >= cnt_total && cnt_blue > cnt_green + slack) return COLOR_BLUE;
        if (5 * cnt_green >= cnt_total && cnt_green > cnt_blue + slack) return COLOR_GREEN;
        if (50 * cnt_yellow >= 9 * cnt_total) return COLOR_YELLOW;
        if (10 * cnt_white >= 3 * cnt_total) return COLOR_WHITE;
        return COLOR_NONE;
    endfunction

    function automatic void set_reg(input t_cfg_idx idx, input logic [12:0] data);
        case (idx)
            REG_IMAGE_WIDTH:  cfg_width  = int'(data[11:0]);
            REG_IMAGE_HEIGHT: cfg_height = int'(data[11:0]);
            REG_BOX_LEFT:     cfg_left   = int'($signed(data));
            REG_BOX_RIGHT:    cfg_right  = int'($signed(data));
            REG_BOX_TOP:      cfg_top    = int'($signed(data));
            REG_BOX_BOTTOM:   cfg_bottom = int'($signed(data));
            default: ;
        endcase
    endfunction

    task automatic track_pixel(input t_pixel px, output t_vote v);
        if (span_hit(int'(px.column), cfg_left, cfg_right, cfg_width) &&
            span_hit(int'(px.row), cfg_top, cfg_bottom, cfg_height)) begin
            cnt_total = sat_inc(cnt_total);
            case (pixel_class(int'(px.red), int'(px.green), int'(px.blue)))
                COLOR_BLUE:   cnt_blue   = sat_inc(cnt_blue);
                COLOR_GREEN:  cnt_green  = sat_inc(cnt_green);
                COLOR_YELLOW: cnt_yellow = sat_inc(cnt_yellow);
                COLOR_WHITE:  cnt_white  = sat_inc(cnt_white);
                COLOR_BLACK:  cnt_black  = sat_inc(cnt_black);
                default: ;
            endcase
        end
        v.color = plate_vote();
        v.count = t_cnt'(cnt_total);
        if (px.frame_end) begin
            cnt_total  = 0;
            cnt_black  = 0;
            cnt_blue   = 0;
            cnt_green  = 0;
            cnt_yellow = 0;
            cnt_white  = 0;
        end
    endtask

    task automatic push_pixel(input t_pixel px, input bit has_typed, input t_vote typed);
        t_vote v;
        i_valid     <= 1'b1;
        i_red       <= px.red;
        i_green     <= px.green;
        i_blue      <= px.blue;
        i_column    <= px.column;
        i_row       <= px.row;
        i_frame_end <= px.frame_end;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        track_pixel(px, v);
        if (px.frame_end) expected_votes.push_back(has_typed ? typed : v);
        if (!steady && $urandom_range(0, 99) < 16) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < 30);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_votes.size() != 0) @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int w, input int h, input int l, input int r,
                                 input int t, input int b);
        logic [12:0] vals [7];
        vals = '{13'h1FFF, 13'(w), 13'(h), 13'(l), 13'(r), 13'(t), 13'(b)};
        wait_drained();
        for (int k = 0; k < 7; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= WRITE_ORDER[k];
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            set_reg(WRITE_ORDER[k], vals[k]);
        end
        i_cfg_valid <= 1'b0;
        repeat (3) @(posedge i_clk);
    endtask

    function automatic int coord_near(input int lo, input int hi);
        int a;
        int z;
        a = ((lo < hi) ? lo : hi) - 3;
        z = ((lo < hi) ? hi : lo) + 3;
        if (a < 0) a = 0;
        if (z > 2047) z = 2047;
        if (a > z) return $urandom_range(0, 2047);
        return $urandom_range(z, a);
    endfunction

    task automatic make_pixel(input t_color theme, output t_pixel px);
        int r;
        int g;
        int b;
        int base;
        if ($urandom_range(0, 3) == 0) theme = COLOR_NONE;
        case (theme)
            COLOR_BLACK: begin
                r = $urandom_range(0, 38);
                g = $urandom_range(0, 38);
                b = $urandom_range(0, 38);
            end
            COLOR_BLUE: begin
                b = $urandom_range(60, 255);
                r = $urandom_range(0, b / 3);
                g = $urandom_range(0, b / 2);
            end
            COLOR_GREEN: begin
                g = $urandom_range(60, 255);
                r = $urandom_range(0, g / 2);
                b = $urandom_range(0, g / 3);
            end
            COLOR_YELLOW: begin
                r = $urandom_range(100, 255);
                g = $urandom_range(r / 4, r);
                b = $urandom_range(0, r / 5);
            end
            COLOR_WHITE: begin
                base = $urandom_range(140, 255);
                r = base - int'($urandom_range(0, 25));
                g = base - int'($urandom_range(0, 25));
                b = base - int'($urandom_range(0, 25));
            end
            default: begin
                r = $urandom_range(0, 255);
                g = $urandom_range(0, 255);
                b = $urandom_range(0, 255);
            end
        endcase
        px.red   = 8'(r);
        px.green = 8'(g);
        px.blue  = 8'(b);
        if ($urandom_range(0, 9) == 0) begin
            px.column = 11'($urandom_range(0, 2047));
            px.row    = 11'($urandom_range(0, 2047));
        end else begin
            px.column = 11'(coord_near(cfg_left, cfg_right));
            px.row    = 11'(coord_near(cfg_top, cfg_bottom));
        end
        px.frame_end = 1'b0;
    endtask

    // frames of pixels; about one in ten runs on into the next frame
    task automatic run_frames(input int budget, input int max_len);
        t_pixel px;
        t_vote  unused;
        t_color theme;
        int     len;
        unused = '0;
        while (budget > 0) begin
            len = $urandom_range(1, max_len);
            if (len > budget) len = budget;
            theme = t_color'($urandom_range(0, 5));
            for (int k = 0; k < len; k++) begin
                make_pixel(theme, px);
                px.frame_end = (k == len - 1) && ($urandom_range(0, 9) != 0);
                push_pixel(px, 1'b0, unused);
            end
            budget -= len;
        end
    endtask

    initial begin
        t_pixel px;
        t_vote  typed;
        int     w;
        int     h;
        int     l;
        int     r;
        int     t;
        int     b;
        int     ew;
        int     eh;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_PROBES; k++) begin
            px.red       = probes[k].red;
            px.green     = probes[k].green;
            px.blue      = probes[k].blue;
            px.column    = probes[k].column;
            px.row       = probes[k].row;
            px.frame_end = probes[k].frame_end;
            typed.color  = probes[k].color;
            typed.count  = probes[k].count;
            push_pixel(px, probes[k].typed, typed);
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: apply_setting(2048, 2048, 0, 59, 0, 29);
                1: apply_setting(1, 1, 0, 0, 0, 0);
                2: apply_setting(16, 16, -30, 12, -6, 18);
                3: apply_setting(0, 16, 0, 20, 0, 20);
                4: apply_setting(4095, 4095, -2048, 4095, -2048, 4095);
                5: apply_setting(24, 12, 40, 10, 2, 9);
                6: apply_setting(2048, 2048, 3000, 3100, 0, 10);
                10: begin
                    w = $urandom_range(0, 8191);
                    h = $urandom_range(0, 8191);
                    apply_setting(w, h, int'($signed(13'($urandom))),
                                  int'($signed(13'($urandom))),
                                  int'($signed(13'($urandom))),
                                  int'($signed(13'($urandom))));
                end
                default: begin
                    w  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(1, 48);
                    h  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 8191)
                                                      : $urandom_range(1, 48);
                    ew = w & 12'hFFF;
                    eh = h & 12'hFFF;
                    if (ew > MAX_IMAGE_DIM) ew = MAX_IMAGE_DIM;
                    if (eh > MAX_IMAGE_DIM) eh = MAX_IMAGE_DIM;
                    if (ew == 0) ew = 8;
                    if (eh == 0) eh = 8;
                    l = int'($urandom_range(0, ew + 12)) - 8;
                    r = l + int'($urandom_range(0, 48)) - 6;
                    t = int'($urandom_range(0, eh + 12)) - 8;
                    b = t + int'($urandom_range(0, 48)) - 6;
                    apply_setting(w, h, l, r, t, b);
                end
            endcase
            steady <= (ph == 2);
            if (ph == 0) begin
                run_frames(35, 24);
                wait_drained();
                run_frames(35, 24);
            end else if (ph == 4) begin
                // output stalled while short frames keep coming
                hold_asked <= hold_asked + 1;
                run_frames(80, 2);
            end else begin
                run_frames(60, 24);
            end
        end

        wait_drained();
        if (fails == 0) begin
            $display("region_hsv_color_vote regression: pass");
        end else begin
            $display("region_hsv_color_vote regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
